/* hw/rtl/tclp_pkg.sv */
// Shared package for the terminal command line parser.
// Holds result codes, character constants, controller/datapath structs and helpers.
// No dependencies.
package tclp_pkg;

    localparam int LINE_LENGTH_DEF = 32;

    localparam int KIND_W = 3;
    localparam int SPEED_W = 16;

    localparam logic [KIND_W-1:0] KIND_SET_SPEED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LASER_OFF = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LASER_ON  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_SPEED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD_SPEED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_INVALID   = 3'd6;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_DEL  = 8'h7F;
    localparam logic [7:0] CHAR_BS   = 8'h08;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_L    = 8'h4C;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    localparam logic [1:0] CLS_SS = 2'd0;
    localparam logic [1:0] CLS_SL = 2'd1;
    localparam logic [1:0] CLS_ST = 2'd2;

    typedef struct packed {
        logic edit;
        logic start;
        logic fetch;
        logic eval;
        logic emit;
    } tclp_cmd_t;

    typedef struct packed {
        logic line_end;
        logic scan_done;
        logic out_free;
    } tclp_status_t;

    function automatic logic letter_is(input logic [7:0] c, input logic [7:0] upper);
        letter_is = (c == upper) || (c == (upper | CASE_BIT));
    endfunction

endpackage

/* hw/rtl/tclp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

/* hw/rtl/tclp_ctrl.sv */
// Controller state machine for the terminal command line parser.
// Sequences line editing, the line scan and the hand-off of the result word.
// Depends on tclp_pkg.
module tclp_ctrl import tclp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  tclp_status_t status,
    output tclp_cmd_t    cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status.line_end) begin
                        cmd.start = 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        cmd.edit = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* hw/rtl/tclp_datapath.sv */
// Datapath of the terminal command line parser: line store, write position,
// command decode registers, laser status and the result word register.
// Depends on tclp_pkg and tclp_ram.
module tclp_datapath import tclp_pkg::*; #(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_rx_byte,
    input  tclp_cmd_t          cmd,
    output tclp_status_t       status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_command_kind,
    output logic [SPEED_W-1:0] m_speed_value,
    output logic               m_laser_on
);
    localparam int AW = $clog2(LINE_LENGTH);
    localparam logic [AW-1:0] LAST_POS = AW'(LINE_LENGTH - 1);

    logic [AW-1:0]      wp_reg, wp_next;
    logic               line_mode_reg, line_mode_next;
    logic               laser_reg, laser_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [1:0]         cls_reg, cls_next;
    logic [SPEED_W-1:0] value_reg, value_next;
    logic               has_digit_reg, has_digit_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic               out_laser_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    logic [7:0]         ch;
    logic               erase;
    logic               done;
    logic [3:0]         digit;
    logic [SPEED_W-1:0] acc;

    tclp_ram #(
        .WIDTH(8),
        .DEPTH(LINE_LENGTH)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign erase = (s_rx_byte == CHAR_DEL) || (s_rx_byte == CHAR_BS);
    assign ch = (idx_reg < wp_reg) ? rd_data : 8'h00;
    assign digit = 4'(ch - CHAR_ZERO);
    assign acc = {value_reg[SPEED_W-4:0], 3'b000} + {value_reg[SPEED_W-2:0], 1'b0}
        + SPEED_W'(digit);
    assign rd_addr = cmd.eval ? AW'(idx_reg + 1'b1) : (cmd.fetch ? '0 : idx_reg);

    always_comb begin
        wr_en = 1'b0;
        wr_addr = wp_reg;
        wr_data = s_rx_byte;
        wp_next = wp_reg;
        line_mode_next = line_mode_reg;
        if (cmd.edit) begin
            line_mode_next = 1'b1;
            if (erase) begin
                if (wp_reg != '0) begin
                    wr_en = 1'b1;
                    wr_addr = AW'(wp_reg - 1'b1);
                    wr_data = 8'h00;
                    wp_next = AW'(wp_reg - 1'b1);
                end
            end else begin
                wr_en = 1'b1;
                if (wp_reg == LAST_POS) begin
                    wp_next = '0;
                    line_mode_next = 1'b0;
                end else begin
                    wp_next = AW'(wp_reg + 1'b1);
                end
            end
        end
        if (cmd.emit) begin
            wp_next = '0;
            line_mode_next = 1'b0;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        cls_next = cls_reg;
        value_next = value_reg;
        has_digit_next = has_digit_reg;
        kind_next = kind_reg;
        done = 1'b0;
        if (cmd.start) begin
            idx_next = '0;
            value_next = '0;
            has_digit_next = 1'b0;
        end
        if (cmd.eval) begin
            idx_next = AW'(idx_reg + 1'b1);
            if (idx_reg == '0) begin
                if (!letter_is(ch, CHAR_S)) begin
                    done = 1'b1;
                    kind_next = KIND_INVALID;
                end
            end else if (idx_reg == AW'(1)) begin
                if (letter_is(ch, CHAR_S)) begin
                    cls_next = CLS_SS;
                end else if (letter_is(ch, CHAR_L)) begin
                    cls_next = CLS_SL;
                end else if (letter_is(ch, CHAR_T)) begin
                    cls_next = CLS_ST;
                end else begin
                    done = 1'b1;
                    kind_next = KIND_INVALID;
                end
            end else begin
                case (cls_reg)
                    CLS_SL: begin
                        done = 1'b1;
                        if (ch == CHAR_ZERO) begin
                            kind_next = KIND_LASER_OFF;
                        end else if (ch == CHAR_ONE) begin
                            kind_next = KIND_LASER_ON;
                        end else begin
                            kind_next = KIND_INVALID;
                        end
                    end
                    CLS_ST: begin
                        done = 1'b1;
                        kind_next = letter_is(ch, CHAR_A) ? KIND_STATUS : KIND_INVALID;
                    end
                    CLS_SS: begin
                        if (ch == 8'h00) begin
                            done = 1'b1;
                            kind_next = has_digit_reg ? KIND_SET_SPEED : KIND_NO_SPEED;
                        end else if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
                            done = 1'b1;
                            kind_next = KIND_BAD_SPEED;
                        end else begin
                            value_next = acc;
                            has_digit_next = 1'b1;
                            if (idx_reg == LAST_POS) begin
                                done = 1'b1;
                                kind_next = KIND_SET_SPEED;
                            end
                        end
                    end
                    default: begin
                        done = 1'b1;
                        kind_next = KIND_INVALID;
                    end
                endcase
            end
        end
    end

    always_comb begin
        laser_next = laser_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            if (kind_reg == KIND_LASER_OFF) begin
                laser_next = 1'b0;
            end else if (kind_reg == KIND_LASER_ON) begin
                laser_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            line_mode_reg <= 1'b0;
            laser_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next;
            line_mode_reg <= line_mode_next;
            laser_reg <= laser_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        cls_reg <= cls_next;
        value_reg <= value_next;
        has_digit_reg <= has_digit_next;
        kind_reg <= kind_next;
        if (cmd.emit) begin
            out_kind_reg <= kind_reg;
            out_speed_reg <= (kind_reg == KIND_SET_SPEED) ? value_reg : '0;
            out_laser_reg <= laser_next;
        end
    end

    assign status.line_end = line_mode_reg && (s_rx_byte == CHAR_CR);
    assign status.scan_done = done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_command_kind = out_kind_reg;
    assign m_speed_value = out_speed_reg;
    assign m_laser_on = out_laser_reg;
endmodule

/* hw/rtl/terminal_command_line_parser.sv */
// Terminal command line parser: edits received bytes into a line store and decodes
// one command word at each carriage return that ends a line. At a line end the line
// store is scanned one byte per cycle through the single read port of its RAM; a
// result word that is not yet taken delays the return to accepting input.
// Depends on tclp_pkg.
module terminal_command_line_parser import tclp_pkg::*; #(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_command_kind,
    output logic [SPEED_W-1:0] m_speed_value,
    output logic               m_laser_on
);
    tclp_cmd_t    cmd;
    tclp_status_t status;

    tclp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    tclp_datapath #(
        .LINE_LENGTH(LINE_LENGTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_rx_byte     (s_rx_byte),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_command_kind(m_command_kind),
        .m_speed_value (m_speed_value),
        .m_laser_on    (m_laser_on)
    );
endmodule

/* test/tb_top.sv */
// Testbench for terminal_command_line_parser: sends terminal bytes and checks each decoded
// command word against a line-editing predictor held in a small scoreboard class.
// Depends on tclp_pkg and the terminal_command_line_parser RTL.
module tb_top;
    import tclp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET = 1500;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SPEED_W-1:0] speed;
        logic               laser;
    } cmd_result_t;

    class parse_scoreboard;
        bit          line_open;
        logic [7:0]  line_buf [LINE_LENGTH_DEF];
        int unsigned wpos;
        bit          laser;
        cmd_result_t expected_q [$];
        int          errors;

        function new();
            clear_line();
            laser = 0;
            errors = 0;
        endfunction

        function void clear_line();
            foreach (line_buf[i]) line_buf[i] = 8'h00;
            wpos = 0;
            line_open = 0;
        endfunction

        function void edit(input logic [7:0] b);
            if (b == CHAR_DEL || b == CHAR_BS) begin
                if (wpos > 0) begin
                    wpos--;
                    line_buf[wpos] = 8'h00;
                end
            end else begin
                line_buf[wpos] = b;
                wpos++;
                if (wpos >= LINE_LENGTH_DEF) clear_line();
            end
        endfunction

        function bit is_letter(input logic [7:0] c, input logic [7:0] up);
            return (c == up) || (c == 8'(up + 8'h20));
        endfunction

        function cmd_result_t decode();
            cmd_result_t r;
            logic [7:0]  c0, c1, c2, c;
            logic [15:0] value;
            int          digits;
            bit          bad;
            c0 = line_buf[0];
            c1 = line_buf[1];
            c2 = line_buf[2];
            r.kind = KIND_INVALID;
            r.speed = '0;
            if (is_letter(c0, CHAR_S) && is_letter(c1, CHAR_S)) begin
                value = '0;
                digits = 0;
                bad = 0;
                for (int i = 2; i < LINE_LENGTH_DEF; i++) begin
                    c = line_buf[i];
                    if (c == 8'h00) break;
                    if (c < CHAR_ZERO || c > CHAR_NINE) begin
                        bad = 1;
                        break;
                    end
                    value = 16'(value * 16'd10 + 16'(c - CHAR_ZERO));
                    digits++;
                end
                if (bad) begin
                    r.kind = KIND_BAD_SPEED;
                end else if (digits == 0) begin
                    r.kind = KIND_NO_SPEED;
                end else begin
                    r.kind = KIND_SET_SPEED;
                    r.speed = value;
                end
            end else if (is_letter(c0, CHAR_S) && is_letter(c1, CHAR_L)) begin
                if (c2 == CHAR_ZERO) begin
                    laser = 0;
                    r.kind = KIND_LASER_OFF;
                end else if (c2 == CHAR_ONE) begin
                    laser = 1;
                    r.kind = KIND_LASER_ON;
                end
            end else if (is_letter(c0, CHAR_S) && is_letter(c1, CHAR_T)
                         && is_letter(c2, CHAR_A)) begin
                r.kind = KIND_STATUS;
            end
            r.laser = laser;
            return r;
        endfunction

        function void note_input(input logic [7:0] b);
            if (!line_open) begin
                line_open = 1;
                edit(b);
            end else if (b == CHAR_CR) begin
                expected_q.push_back(decode());
                clear_line();
            end else begin
                edit(b);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(input logic [KIND_W-1:0] kind, input logic [SPEED_W-1:0] speed,
                          input logic laser_bit);
            cmd_result_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word kind %0d speed %0d laser %0b",
                                 kind, speed, laser_bit));
            end else begin
                exp = expected_q.pop_front();
                if (kind !== exp.kind)
                    report($sformatf("command_kind %0d, expected %0d", kind, exp.kind));
                if (speed !== exp.speed)
                    report($sformatf("speed_value %0d, expected %0d", speed, exp.speed));
                if (laser_bit !== exp.laser)
                    report($sformatf("laser_on %0b, expected %0b", laser_bit, exp.laser));
            end
        endtask
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [KIND_W-1:0]  m_command_kind;
    logic [SPEED_W-1:0] m_speed_value;
    logic               m_laser_on;

    parse_scoreboard sb = new();
    int  sent_count = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;

    terminal_command_line_parser i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_kind (m_command_kind),
        .m_speed_value  (m_speed_value),
        .m_laser_on     (m_laser_on)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_rx_byte);
            if (m_valid && m_ready) sb.check_result(m_command_kind, m_speed_value, m_laser_on);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL terminal_command_line_parser");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] rcase(input logic [7:0] up);
        return $urandom_range(0, 1) ? 8'(up + 8'h20) : up;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic send_word(input logic [7:0] b);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        int g;
        send_word(b);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Command bytes sometimes carry a stray character that is erased right away.
    task automatic put_cmd_byte(input logic [7:0] b);
        if ($urandom_range(0, 11) == 0) begin
            put_byte(printable());
            put_byte($urandom_range(0, 1) ? CHAR_DEL : CHAR_BS);
        end
        put_byte(b);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_random_line();
        int         r, n, p;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            put_cmd_byte(rcase(CHAR_S));
            put_cmd_byte(rcase(CHAR_S));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 22) : $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(0, 24) == 0) put_cmd_byte(8'($urandom_range(0, 255)));
                else put_cmd_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
        end else if (r < 45) begin
            put_cmd_byte(rcase(CHAR_S));
            put_cmd_byte(rcase(CHAR_L));
            p = $urandom_range(0, 19);
            if (p < 9) put_cmd_byte(CHAR_ZERO);
            else if (p < 18) put_cmd_byte(CHAR_ONE);
            else put_cmd_byte(printable());
        end else if (r < 55) begin
            put_cmd_byte(rcase(CHAR_S));
            put_cmd_byte(rcase(CHAR_T));
            put_cmd_byte(rcase(CHAR_A));
            repeat ($urandom_range(0, 2)) put_cmd_byte(printable());
        end else if (r < 65) begin
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
        end else if (r < 73) begin
            repeat ($urandom_range(29, 40)) put_byte(printable());
        end else if (r < 85) begin
            repeat ($urandom_range(1, 12)) begin
                p = $urandom_range(0, 7);
                case (p)
                    0, 1: b = rcase(CHAR_S);
                    2: b = rcase(CHAR_L);
                    3: b = rcase(CHAR_T);
                    4: b = rcase(CHAR_A);
                    5: b = 8'(CHAR_ZERO + $urandom_range(0, 9));
                    default: b = $urandom_range(0, 1) ? CHAR_DEL : CHAR_BS;
                endcase
                put_byte(b);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                p = $urandom_range(0, 5);
                case (p)
                    0, 1: b = rcase(CHAR_S);
                    2: b = rcase(CHAR_L);
                    3: b = rcase(CHAR_T);
                    4: b = CHAR_ONE;
                    default: b = printable();
                endcase
                put_byte(b);
            end
        end
        if ($urandom_range(0, 19) != 0) put_byte(CHAR_CR);
    endtask

    initial begin
        int g;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        int next_drain;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A carriage return as the first byte is stored, so the line reads as invalid.
        put_byte(CHAR_CR);
        put_byte(CHAR_CR);
        put_text("sl1");
        put_byte(CHAR_CR);
        put_text("SL0");
        put_byte(CHAR_CR);
        put_text("StA");
        put_byte(CHAR_CR);
        put_text("SS");
        put_byte(CHAR_CR);
        put_text("ss");
        put_byte(8'hFF);
        put_byte(CHAR_CR);
        put_text("SS9");
        put_byte(CHAR_DEL);
        put_text("5");
        put_byte(CHAR_CR);
        put_byte(CHAR_S);
        put_byte(8'h00);
        put_byte(CHAR_CR);
        drain_results();

        next_drain = sent_count + $urandom_range(150, 350);
        while (sent_count < ITEM_TARGET) begin
            quiet = (sent_count >= 600 && sent_count < 800);
            send_random_line();
            if (sent_count >= next_drain) begin
                drain_results();
                next_drain = sent_count + $urandom_range(150, 350);
            end
        end
        quiet = 0;
        s_valid <= 1'b0;

        drain_results();
        repeat (LINE_LENGTH_DEF + 8) @(posedge aclk);
        if (sb.pending() != 0) sb.report("command words still missing at end of run");
        if (sb.errors == 0) begin
            $display("PASS terminal_command_line_parser");
        end else begin
            $display("FAIL terminal_command_line_parser");
        end
        $finish;
    end
endmodule
